// ===== hw/rtl/tcw_pkg.sv =====
package tcw_pkg;

  // Payload widths of the command and result ports
  localparam int CHAR_W   = 8;
  localparam int CELL_W   = 16;
  localparam int POS_W    = 11;
  localparam int IN_ADDR_W = 11;

  // Configuration port
  localparam int APB_AW = 1;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_ATTRIBUTE = 1'b0;
  localparam logic [CHAR_W-1:0] ATTR_RESET     = 8'h07;

  // Control bytes honored by the interpreted put
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;

  typedef enum logic [1:0] {
    ACT_RAW    = 2'd0,
    ACT_INTERP = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  // Cursor move request, at most one field set
  typedef struct packed {
    logic put;
    logic tab;
    logic newline;
  } cursor_cmd_t;

endpackage

// ===== hw/rtl/text_mode_console_writer.sv =====
// Text-mode console writer: a COLUMNS x ROWS screen of 16-bit cells (character in
// bits 7..0, attribute register in bits 15..8) plus a cursor. A command is taken when
// start is high and busy is low; its single result appears on the result ports for
// exactly one cycle with done_o high and cannot be held off. A put, tab or newline
// that does not scroll, and a cell read, pass through one execute state for the cell
// write or read and the cursor step. A put, tab or newline that scrolls walks the
// whole store through the one RAM port pair, one cell per cycle: it copies each row
// up and then blanks the bottom row. A clear zeroes the whole store the same way.
// busy drops while the result is shown, so the next command can be taken at the
// edge that takes the result. After reset the store is zeroed by a sweep over all
// cells during which busy is high; attribute writes are accepted at any time the
// block is idle.
module text_mode_console_writer #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      action_i,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code_i,
  input  logic [tcw_pkg::IN_ADDR_W-1:0]   cell_address_i,
  output logic                            done_o,
  output logic [tcw_pkg::POS_W-1:0]       cursor_position_o,
  output logic [tcw_pkg::CELL_W-1:0]      read_data_o,
  output logic                            scrolled_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcw_pkg::APB_AW-1:0]      paddr,
  input  logic [tcw_pkg::APB_DW-1:0]      pwdata,
  output logic [tcw_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  import tcw_pkg::*;

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int AW        = $clog2(CELLS);
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
  localparam int AXW       = ((AW > IN_ADDR_W) ? AW : IN_ADDR_W) + 1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR
  } state_e;

  state_e                 state_q;
  action_e                act_q;
  logic [CHAR_W-1:0]      char_q;
  logic [IN_ADDR_W-1:0]   addr_q;
  logic [CHAR_W-1:0]      attr_q;
  logic [AW-1:0]          cnt_q;
  logic [AW-1:0]          dst_q;
  logic                   move_q;
  logic                   done_q;
  logic                   scr_q;
  logic [CELL_W-1:0]      rdata_q;

  logic                   cfg_wr;
  logic                   ctrl_tab;
  logic                   ctrl_nl;
  logic                   in_range;
  logic [AXW-1:0]         addr_in_wide;
  logic [AXW-1:0]         addr_q_wide;
  cursor_cmd_t            cmd;
  logic [AW-1:0]          cell_index;
  logic                   cur_scroll;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [CELL_W-1:0]      ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [CELL_W-1:0]      ram_rdata;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_ATTRIBUTE);
  assign prdata = (paddr == ADDR_ATTRIBUTE) ? APB_DW'(attr_q) : '0;

  // Decode the latched command
  assign ctrl_tab     = (act_q == ACT_INTERP) && (char_q == CHAR_TAB);
  assign ctrl_nl      = (act_q == ACT_INTERP) && (char_q == CHAR_NEWLINE);
  assign addr_in_wide = AXW'(cell_address_i);
  assign addr_q_wide  = AXW'(addr_q);
  assign in_range     = addr_q_wide < AXW'(CELLS);

  // Steer the RAM ports and the cursor from the sequencer state
  always_comb begin
    cmd       = '0;
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = '0;
    ram_raddr = AW'(addr_in_wide);
    unique case (state_q) inside
      ST_IDLE: begin
        ram_raddr = AW'(addr_in_wide);
      end
      ST_EXEC: begin
        if ((act_q == ACT_RAW) || ((act_q == ACT_INTERP) && !ctrl_tab && !ctrl_nl)) begin
          cmd.put   = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = cell_index;
          ram_wdata = {attr_q, char_q};
        end
        cmd.tab     = ctrl_tab;
        cmd.newline = ctrl_nl;
      end
      ST_SCROLL: begin
        ram_raddr = cnt_q + AW'(COLUMNS);
        ram_we    = move_q;
        ram_waddr = dst_q;
        ram_wdata = ram_rdata;
      end
      ST_BLANK, ST_CLEAR, ST_INIT: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer: accept, execute, and walk the store for scroll, clear and the reset sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      act_q   <= ACT_RAW;
      char_q  <= '0;
      addr_q  <= '0;
      attr_q  <= ATTR_RESET;
      cnt_q   <= '0;
      dst_q   <= '0;
      move_q  <= 1'b0;
      done_q  <= 1'b0;
      scr_q   <= 1'b0;
      rdata_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_wr) begin
        attr_q <= pwdata[CHAR_W-1:0];
      end
      unique case (state_q) inside
        ST_IDLE: begin
          if (start) begin
            act_q   <= action_e'(action_i);
            char_q  <= char_code_i;
            addr_q  <= cell_address_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          rdata_q <= '0;
          scr_q   <= 1'b0;
          unique case (act_q) inside
            ACT_RAW, ACT_INTERP: begin
              if (cur_scroll) begin
                scr_q   <= 1'b1;
                cnt_q   <= '0;
                move_q  <= 1'b0;
                state_q <= ST_SCROLL;
              end else begin
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end
            end
            ACT_READ: begin
              rdata_q <= in_range ? ram_rdata : '0;
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
            ACT_CLEAR: begin
              cnt_q   <= '0;
              state_q <= ST_CLEAR;
            end
            default: begin
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_SCROLL: begin
          // Copy each cell up one row, one read issued per cycle
          if (cnt_q != AW'(LAST_BASE)) begin
            dst_q  <= cnt_q;
            move_q <= 1'b1;
            cnt_q  <= cnt_q + AW'(1);
          end else begin
            move_q  <= 1'b0;
            state_q <= ST_BLANK;
          end
        end
        ST_BLANK: begin
          if (cnt_q == AW'(CELLS - 1)) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        ST_CLEAR, ST_INIT: begin
          if (cnt_q == AW'(CELLS - 1)) begin
            done_q  <= (state_q == ST_CLEAR);
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  tcw_cursor #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_cursor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cell_index_o (cell_index),
    .position_o   (cursor_position_o),
    .scroll_o     (cur_scroll)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign read_data_o = rdata_q;
  assign scrolled_o  = scr_q;

  // A result beat is never followed by another in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result beat repeated");

  // An accepted command makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // A scroll leaves the cursor on the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && scrolled_o) |-> (cell_index >= AW'(LAST_BASE)))
    else $error("scroll left cursor above bottom row");

  // Blanking only touches the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLANK) |-> (cnt_q >= AW'(LAST_BASE)))
    else $error("blank sweep outside bottom row");

  // The copy stage never writes into the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL && move_q) |-> (dst_q < AW'(LAST_BASE)))
    else $error("scroll copy destination out of range");

endmodule

// ===== hw/rtl/tcw_ram.sv =====
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tcw_cursor.sv =====
module tcw_cursor #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tcw_pkg::cursor_cmd_t             cmd_i,
  output logic [$clog2(COLUMNS*ROWS)-1:0]  cell_index_o,
  output logic [tcw_pkg::POS_W-1:0]        position_o,
  output logic                             scroll_o
);

  import tcw_pkg::*;

  localparam int CW  = $clog2(COLUMNS);
  localparam int RW  = $clog2(ROWS);
  localparam int CXW = $clog2(COLUMNS + TAB_WIDTH);
  localparam int PW  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int AW  = $clog2(COLUMNS * ROWS);
  localparam int PXW = (AW > POS_W) ? AW : POS_W;

  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [PW-1:0]  phase_q, phase_d;   // column modulo the tab width
  logic [CXW-1:0] col_adv;
  logic           moving;
  logic           wrap;
  logic           row_inc;
  logic [PXW-1:0] pos_wide;

  // Advance by one for a put, up to the next tab stop for a tab
  always_comb begin
    if (cmd_i.put) begin
      col_adv = CXW'(col_q) + CXW'(1);
    end else begin
      col_adv = CXW'(col_q) + CXW'(TAB_WIDTH) - CXW'(phase_q);
    end
  end

  assign moving   = cmd_i.put | cmd_i.tab | cmd_i.newline;
  assign wrap     = (cmd_i.put | cmd_i.tab) && (col_adv >= CXW'(COLUMNS));
  assign row_inc  = cmd_i.newline | wrap;
  assign scroll_o = row_inc && (row_q == RW'(ROWS - 1));

  // Wrap the column, step the row, hold the row at the bottom on scroll
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    phase_d = phase_q;
    if (moving) begin
      col_d   = row_inc ? '0 : CW'(col_adv);
      row_d   = (row_inc && !scroll_o) ? row_q + RW'(1) : row_q;
      phase_d = (cmd_i.put && !wrap && (phase_q != PW'(TAB_WIDTH - 1))) ?
                phase_q + PW'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
    end
  end

  assign cell_index_o = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign pos_wide     = PXW'(cell_index_o);
  assign position_o   = pos_wide[POS_W-1:0];

endmodule
